// ===== rtl/core/mdtm_pkg.sv =====
// Shared types and constants for the multilink delivery time estimator.
package mdtm_pkg;

  localparam int unsigned QWidth     = 24;
  localparam int unsigned BufWidth   = 32;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned DvdWidth   = 51;
  localparam int unsigned DvsWidth   = 34;
  localparam int unsigned TxWidth    = 35;
  localparam int unsigned StepWidth  = 6;
  localparam int unsigned SumWidth   = 52;
  localparam int unsigned ChunkShift = 11;
  localparam int unsigned BufShift   = 19;

  localparam logic [StepWidth-1:0] DivLastStep = StepWidth'(DvdWidth - 1);
  localparam logic [9:0]           KiloFactor  = 10'd1000;
  localparam logic [QWidth-1:0]    DefBwReset  = 24'd256;
  localparam logic [QWidth-1:0]    DefLatReset = 24'd12800;

  typedef enum logic {
    CFG_DEFAULT_BW  = 1'b0,
    CFG_DEFAULT_LAT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [QWidth-1:0]   chunk_size;
    logic [QWidth-1:0]   bandwidth;
    logic                bandwidth_known;
    logic [QWidth-1:0]   latency;
    logic                latency_known;
    logic [BufWidth-1:0] buffer_occupancy;
    logic                buffer_known;
    logic                last_link;
  } link_t;

  typedef struct packed {
    logic [TimeWidth-1:0] delivery_time;
    logic                 saturated;
  } result_t;

  typedef struct packed {
    logic load;
    logic div_init_tx;
    logic div_step;
    logic div_init_buf;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic bw_zero;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/mdtm_div.sv =====
// Restoring shift-subtract divider that produces one quotient bit per cycle while step is high.
module mdtm_div (
  input  logic                          clk,
  input  logic                          init,
  input  logic                          step,
  input  logic [mdtm_pkg::DvdWidth-1:0] dividend,
  input  logic [mdtm_pkg::DvsWidth-1:0] divisor,
  output logic [mdtm_pkg::DvdWidth-1:0] quotient,
  output logic                          last_step
);
  import mdtm_pkg::*;

  logic [DvdWidth-1:0]  quo;
  logic [DvsWidth-1:0]  rem;
  logic [DvsWidth-1:0]  dvs;
  logic [StepWidth-1:0] cnt;
  logic [DvsWidth:0]    trial;
  logic [DvsWidth:0]    diff;
  logic                 ge;

  always_comb begin
    trial = {rem, quo[DvdWidth-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (init) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (step) begin
      quo <= {quo[DvdWidth-2:0], ge};
      rem <= ge ? diff[DvsWidth-1:0] : trial[DvsWidth-1:0];
      cnt <= cnt + StepWidth'(1);
    end
  end

  assign quotient  = quo;
  assign last_step = (cnt == DivLastStep);

endmodule

// ===== rtl/core/mdtm_dpath.sv =====
// Datapath: configuration registers, link operands, divider and frame maximum.
module mdtm_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  mdtm_pkg::ctrl_cmd_t         cmd,
  output mdtm_pkg::dp_status_t        status,
  input  mdtm_pkg::link_t             link,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [mdtm_pkg::QWidth-1:0] cfg_data,
  output mdtm_pkg::result_t           result,
  output logic                        result_strobe
);
  import mdtm_pkg::*;

  logic [QWidth-1:0]    def_bw;
  logic [QWidth-1:0]    def_lat;
  logic [QWidth-1:0]    chunk;
  logic [QWidth-1:0]    bw;
  logic [QWidth-1:0]    lat;
  logic [BufWidth-1:0]  buf_bytes;
  logic                 last;
  logic [DvsWidth-1:0]  bw_kilo;
  logic [TxWidth-1:0]   tx;
  logic [TimeWidth-1:0] running_max;
  logic                 overflow_seen;

  logic                 div_init;
  logic [DvdWidth-1:0]  div_dividend;
  logic [DvsWidth-1:0]  div_divisor;
  logic [DvdWidth-1:0]  quotient;
  logic                 div_last;

  logic [SumWidth-1:0]  sum;
  logic                 link_sat;
  logic [TimeWidth-1:0] link_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_bw  <= DefBwReset;
      def_lat <= DefLatReset;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEFAULT_BW:  def_bw  <= cfg_data;
        CFG_DEFAULT_LAT: def_lat <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chunk     <= link.chunk_size;
      bw        <= link.bandwidth_known ? link.bandwidth : def_bw;
      lat       <= link.latency_known ? link.latency : def_lat;
      buf_bytes <= link.buffer_known ? link.buffer_occupancy : '0;
      last      <= link.last_link;
    end
    if (cmd.div_init_tx) begin
      bw_kilo <= DvsWidth'(bw) * DvsWidth'(KiloFactor);
    end
    if (cmd.div_init_buf) begin
      tx <= quotient[TxWidth-1:0];
    end
  end

  always_comb begin
    div_init     = cmd.div_init_tx | cmd.div_init_buf;
    div_dividend = cmd.div_init_tx
                 ? {{(DvdWidth - QWidth - ChunkShift){1'b0}}, chunk, {ChunkShift{1'b0}}}
                 : {buf_bytes, {BufShift{1'b0}}};
    div_divisor  = cmd.div_init_tx ? DvsWidth'(bw) : bw_kilo;
  end

  mdtm_div u_div (
    .clk       (clk),
    .init      (div_init),
    .step      (cmd.div_step),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (quotient),
    .last_step (div_last)
  );

  always_comb begin
    sum       = SumWidth'(tx) + SumWidth'(lat) + SumWidth'(quotient);
    link_sat  = (bw == '0) || (sum[SumWidth-1:TimeWidth] != '0);
    link_time = link_sat ? '1 : sum[TimeWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max   <= '0;
      overflow_seen <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cmd.update) begin
        if (link_time > running_max) begin
          running_max <= link_time;
        end
        overflow_seen <= overflow_seen | link_sat;
      end
      if (cmd.emit && last) begin
        result_strobe <= 1'b1;
        running_max   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && last) begin
      result.delivery_time <= running_max;
      result.saturated     <= overflow_seen;
    end
  end

  always_comb begin
    status.skip     = (chunk == '0);
    status.bw_zero  = (bw == '0);
    status.div_last = div_last;
  end

endmodule

// ===== rtl/core/mdtm_ctrl.sv =====
// Controller state machine that sequences one link record through the datapath.
module mdtm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mdtm_pkg::dp_status_t status,
  output mdtm_pkg::ctrl_cmd_t  cmd
);
  import mdtm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOAD    = 7'b0000010,
    S_DIV_TX  = 7'b0000100,
    S_SAVE_TX = 7'b0001000,
    S_DIV_BUF = 7'b0010000,
    S_UPDATE  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (status.skip) begin
          state_next = S_FINISH;
        end else if (status.bw_zero) begin
          state_next = S_UPDATE;
        end else begin
          cmd.div_init_tx = 1'b1;
          state_next      = S_DIV_TX;
        end
      end
      S_DIV_TX: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_SAVE_TX;
        end
      end
      S_SAVE_TX: begin
        cmd.div_init_buf = 1'b1;
        state_next       = S_DIV_BUF;
      end
      S_DIV_BUF: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/multilink_delivery_time_max.sv =====
// Top level of the multilink frame delivery time estimator.
//
// A link record is taken on a cycle with start high and busy low. Busy then
// stays high while the record is processed; a new record can be started once
// busy is low again.
// A counted link passes through S_LOAD, which also starts the transmission
// time division on the shared bit-serial divider, S_DIV_TX, S_SAVE_TX, which
// starts the buffer drain division, S_DIV_BUF, S_UPDATE and S_FINISH. The two
// divisions make up most of the busy time. A link with a zero chunk goes from
// S_LOAD to S_FINISH and one with zero bandwidth from S_LOAD to S_UPDATE.
// When the record carries last_link, the frame maximum and its saturation flag
// are registered on result, with result_strobe high for exactly one cycle as
// busy falls, and the frame state clears. The receiver cannot stall.
// The configuration channel takes a write in every cycle (cfg_ready is tied
// high); index 0 sets the default bandwidth and index 1 the default latency.
// Writes are meant to happen only while busy is low.
// Synchronous reset returns the controller to idle, clears the frame maximum
// and restores the default registers to 1.0 Mbps and 50.0 ms.
module multilink_delivery_time_max (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  mdtm_pkg::link_t             link,
  output mdtm_pkg::result_t           result,
  output logic                        result_strobe,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [mdtm_pkg::QWidth-1:0] cfg_data
);
  import mdtm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mdtm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mdtm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .link          (link),
    .cfg_write     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
